// File: src/sng_pkg.sv
package sng_pkg;

	localparam int SIDE_DEF = 3;
	localparam int VALUE_W = 7;
	localparam int KIND_W = 3;
	localparam int AMOUNT_W = 9;
	localparam int CAP_INT = 100;

	localparam logic [VALUE_W-1:0] VALUE_CAP = 7'd100;
	localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 9'd511;

	localparam logic [KIND_W-1:0] KIND_ASC = 3'd0;
	localparam logic [KIND_W-1:0] KIND_DESC = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GRID = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ROW = 3'd3;
	localparam logic [KIND_W-1:0] KIND_COL = 3'd4;

	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_INSERT = 2'd1,
		OP_SHIFT_DN = 2'd2,
		OP_SHIFT_UP = 2'd3
	} cell_op_t;

	typedef enum logic [4:0] {
		ST_COLLECT = 5'b00001,
		ST_ASC = 5'b00010,
		ST_DESC = 5'b00100,
		ST_GRID = 5'b01000,
		ST_COLS = 5'b10000
	} state_t;

	function automatic logic [AMOUNT_W-1:0] sat_amount(input logic [15:0] s);
		logic [AMOUNT_W-1:0] r;
		if (s > 16'(AMOUNT_MAX)) begin
			r = AMOUNT_MAX;
		end else begin
			r = s[AMOUNT_W-1:0];
		end
		return r;
	endfunction

endpackage

// File: src/sng_cell.sv
module sng_cell (
	input logic clk,
	input sng_pkg::cell_op_t op,
	input logic [sng_pkg::VALUE_W-1:0] sample,
	input logic [sng_pkg::VALUE_W-1:0] lo,
	input logic [sng_pkg::VALUE_W-1:0] hi,
	input logic occ,
	input logic gt_in,
	output logic gt_out,
	output logic [sng_pkg::VALUE_W-1:0] held
);

	logic [sng_pkg::VALUE_W-1:0] held_q;

	assign gt_out = !occ || (held_q > sample);
	assign held = held_q;

	always_ff @(posedge clk) begin
		case (op)
			sng_pkg::OP_INSERT: begin
				if (gt_out) begin
					held_q <= gt_in ? lo : sample;
				end
			end
			sng_pkg::OP_SHIFT_DN: begin
				held_q <= hi;
			end
			sng_pkg::OP_SHIFT_UP: begin
				held_q <= lo;
			end
			default: begin
				held_q <= held_q;
			end
		endcase
	end

endmodule

// File: src/sort_nine_and_grid_sums_unit.sv
// Sorts a set of SIDE*SIDE samples and reports the sorted lists and grid sums.
// Input channel: sample with sample_valid / sample_stall. Samples above 100
// are clamped to 100. Each sample is inserted into a sorted chain of cells in
// the cycle it is taken, so the input side takes one transaction per cycle
// while a set is being collected.
// Once the last sample of a set is taken, sample_stall rises and the report of
// 3*SIDE*SIDE + 2*SIDE transactions (33 for SIDE = 3) leaves on kind, amount
// and final_res with result_valid / result_stall: ascending list, descending
// list, the grid with row sums, then column sums, final_res marking the last.
// The last sample moves the sequencer out of collection and the first result is
// then registered in the output register, followed by one result per cycle while
// result_stall is low; the chain rotates once per list or grid result to present
// the next element and holds for the row and column sums.
// A stall on the result side holds the output register and freezes the chain;
// the next set is taken as soon as the last result sits in the output register.
// Reset clears the fill count, the sequencer and result_valid; cell contents
// are not cleared.
module sort_nine_and_grid_sums_unit #(
	parameter int SIDE = sng_pkg::SIDE_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input logic [sng_pkg::VALUE_W-1:0] sample,
	output logic result_valid,
	input logic result_stall,
	output logic [sng_pkg::KIND_W-1:0] kind,
	output logic [sng_pkg::AMOUNT_W-1:0] amount,
	output logic final_res
);

	localparam int N = SIDE * SIDE;
	localparam int IDX_W = $clog2(N);
	localparam int COL_W = $clog2(SIDE);
	localparam int SUM_W = $clog2(SIDE * sng_pkg::CAP_INT + 1);

	sng_pkg::state_t state_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] idx_q;
	logic [COL_W-1:0] col_q;
	logic sum_slot_q;
	logic [SUM_W-1:0] row_q;
	logic [SUM_W-1:0] col_acc_q [SIDE];

	logic result_valid_q;
	logic [sng_pkg::KIND_W-1:0] kind_q;
	logic [sng_pkg::AMOUNT_W-1:0] amount_q;
	logic final_q;

	logic [sng_pkg::VALUE_W-1:0] sample_sat;
	logic [sng_pkg::VALUE_W-1:0] held [N];
	logic gt [N];
	logic occ [N];
	sng_pkg::cell_op_t op;
	logic take;
	logic adv;
	logic [sng_pkg::VALUE_W-1:0] head_dn;
	logic [sng_pkg::VALUE_W-1:0] head_up;
	logic [SUM_W-1:0] ring_in;

	assign sample_sat = (sample > sng_pkg::VALUE_CAP) ? sng_pkg::VALUE_CAP : sample;
	assign sample_stall = (state_q != sng_pkg::ST_COLLECT);
	assign take = sample_valid && !sample_stall;
	assign adv = !result_valid_q || !result_stall;
	assign head_dn = held[0];
	assign head_up = held[N-1];

	always_comb begin
		op = sng_pkg::OP_HOLD;
		case (state_q)
			sng_pkg::ST_COLLECT: begin
				if (take) begin
					op = sng_pkg::OP_INSERT;
				end
			end
			sng_pkg::ST_ASC: begin
				if (adv) begin
					op = sng_pkg::OP_SHIFT_DN;
				end
			end
			sng_pkg::ST_DESC: begin
				if (adv) begin
					op = sng_pkg::OP_SHIFT_UP;
				end
			end
			sng_pkg::ST_GRID: begin
				if (adv && !sum_slot_q) begin
					op = sng_pkg::OP_SHIFT_UP;
				end
			end
			default: begin
				op = sng_pkg::OP_HOLD;
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < N; gi++) begin : g_cell
			assign occ[gi] = (IDX_W'(gi) < fill_q);
			sng_cell u_cell (
				.clk(clk),
				.op(op),
				.sample(sample_sat),
				.lo(held[(gi + N - 1) % N]),
				.hi(held[(gi + 1) % N]),
				.occ(occ[gi]),
				.gt_in((gi == 0) ? 1'b0 : gt[(gi + N - 1) % N]),
				.gt_out(gt[gi]),
				.held(held[gi])
			);
		end
	endgenerate

	assign ring_in = col_acc_q[0] +
		((state_q == sng_pkg::ST_GRID) ? SUM_W'(head_up) : SUM_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sng_pkg::ST_COLLECT;
			fill_q <= '0;
			idx_q <= '0;
			col_q <= '0;
			sum_slot_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				sng_pkg::ST_COLLECT: begin
					if (result_valid_q && !result_stall) begin
						result_valid_q <= 1'b0;
					end
					if (take) begin
						if (fill_q == IDX_W'(N - 1)) begin
							fill_q <= '0;
							idx_q <= '0;
							state_q <= sng_pkg::ST_ASC;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				sng_pkg::ST_ASC: begin
					if (adv) begin
						result_valid_q <= 1'b1;
						if (idx_q == IDX_W'(N - 1)) begin
							idx_q <= '0;
							state_q <= sng_pkg::ST_DESC;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				sng_pkg::ST_DESC: begin
					if (adv) begin
						result_valid_q <= 1'b1;
						if (idx_q == IDX_W'(N - 1)) begin
							idx_q <= '0;
							col_q <= '0;
							sum_slot_q <= 1'b0;
							state_q <= sng_pkg::ST_GRID;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				sng_pkg::ST_GRID: begin
					if (adv) begin
						result_valid_q <= 1'b1;
						if (sum_slot_q) begin
							sum_slot_q <= 1'b0;
							if (idx_q == '0) begin
								state_q <= sng_pkg::ST_COLS;
							end
						end else begin
							idx_q <= (idx_q == IDX_W'(N - 1)) ? '0 : idx_q + 1'b1;
							if (col_q == COL_W'(SIDE - 1)) begin
								col_q <= '0;
								sum_slot_q <= 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end
					end
				end
				sng_pkg::ST_COLS: begin
					if (adv) begin
						result_valid_q <= 1'b1;
						if (col_q == COL_W'(SIDE - 1)) begin
							col_q <= '0;
							state_q <= sng_pkg::ST_COLLECT;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				default: begin
					result_valid_q <= 1'b0;
					state_q <= sng_pkg::ST_COLLECT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			case (state_q)
				sng_pkg::ST_ASC: begin
					kind_q <= sng_pkg::KIND_ASC;
					amount_q <= sng_pkg::AMOUNT_W'(head_dn);
					final_q <= 1'b0;
				end
				sng_pkg::ST_DESC: begin
					kind_q <= sng_pkg::KIND_DESC;
					amount_q <= sng_pkg::AMOUNT_W'(head_up);
					final_q <= 1'b0;
					if (idx_q == IDX_W'(N - 1)) begin
						row_q <= '0;
						for (int k = 0; k < SIDE; k++) begin
							col_acc_q[k] <= '0;
						end
					end
				end
				sng_pkg::ST_GRID: begin
					final_q <= 1'b0;
					if (sum_slot_q) begin
						kind_q <= sng_pkg::KIND_ROW;
						amount_q <= sng_pkg::sat_amount(16'(row_q));
						row_q <= '0;
					end else begin
						kind_q <= sng_pkg::KIND_GRID;
						amount_q <= sng_pkg::AMOUNT_W'(head_up);
						row_q <= row_q + SUM_W'(head_up);
						for (int k = 0; k < SIDE - 1; k++) begin
							col_acc_q[k] <= col_acc_q[k+1];
						end
						col_acc_q[SIDE-1] <= ring_in;
					end
				end
				sng_pkg::ST_COLS: begin
					kind_q <= sng_pkg::KIND_COL;
					amount_q <= sng_pkg::sat_amount(16'(col_acc_q[0]));
					final_q <= (col_q == COL_W'(SIDE - 1));
					for (int k = 0; k < SIDE - 1; k++) begin
						col_acc_q[k] <= col_acc_q[k+1];
					end
					col_acc_q[SIDE-1] <= ring_in;
				end
				default: begin
					kind_q <= kind_q;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign kind = kind_q;
	assign amount = amount_q;
	assign final_res = final_q;

`ifndef SYNTHESIS
	a_final_is_col: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && final_res |-> kind == sng_pkg::KIND_COL)
		else $error("final_res on a result that is not a column sum");

	a_last_sample_starts_report: assert property (@(posedge clk) disable iff (!arst_n)
		take && fill_q == IDX_W'(N - 1) |=> state_q == sng_pkg::ST_ASC)
		else $error("last sample of a set did not start the report");

	a_fill_idle_in_report: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sng_pkg::ST_COLLECT |-> fill_q == '0)
		else $error("fill count not cleared during report");

	generate
		for (gi = 0; gi < N - 1; gi++) begin : g_sorted_chk
			a_chain_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				state_q == sng_pkg::ST_COLLECT && occ[gi+1] |-> held[gi] <= held[gi+1])
				else $error("cell chain out of order");
		end
	endgenerate
`endif

endmodule

// File: dv/sort_nine_and_grid_sums_unit_tb.sv
`timescale 1ns / 1ps

module sort_nine_and_grid_sums_unit_tb;

	localparam int SIDE = sng_pkg::SIDE_DEF;
	localparam int SET_N = SIDE * SIDE;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 60;
	localparam int PRINT_LIMIT = 30;

	typedef enum int {
		MIX_FULL,
		MIX_NEAR_CAP,
		MIX_TINY,
		MIX_CONSTANT
	} sample_mix_t;

	typedef struct packed {
		logic [sng_pkg::KIND_W-1:0] kind;
		logic [sng_pkg::AMOUNT_W-1:0] amount;
		logic final_res;
	} report_entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [sng_pkg::VALUE_W-1:0] sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [sng_pkg::KIND_W-1:0] kind;
	logic [sng_pkg::AMOUNT_W-1:0] amount;
	logic final_res;

	report_entry_t report_q[$];
	logic [sng_pkg::VALUE_W-1:0] set_buf[SET_N];
	int fill = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int error_count = 0;
	int samples_sent = 0;
	int results_seen = 0;
	int reports_done = 0;
	int idle_cycles = 0;

	sort_nine_and_grid_sums_unit #(
		.SIDE(SIDE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.kind(kind),
		.amount(amount),
		.final_res(final_res)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input int exp_v, input int got_v);
		error_count++;
		if (error_count <= PRINT_LIMIT) begin
			$display("%0t mismatch: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
		end
	endtask

	task automatic push_expect(input logic [sng_pkg::KIND_W-1:0] k, input int a,
			input logic f);
		report_entry_t e;
		e.kind = k;
		e.amount = (a > int'(sng_pkg::AMOUNT_MAX)) ? sng_pkg::AMOUNT_MAX :
			sng_pkg::AMOUNT_W'(a);
		e.final_res = f;
		report_q.push_back(e);
	endtask

	task automatic predict_report();
		logic [sng_pkg::VALUE_W-1:0] asc[SET_N];
		logic [sng_pkg::VALUE_W-1:0] desc[SET_N];
		logic [sng_pkg::VALUE_W-1:0] tmp;
		int col_sum[SIDE];
		int row_sum;
		for (int i = 0; i < SET_N; i++) asc[i] = set_buf[i];
		for (int i = 0; i < SET_N - 1; i++) begin
			for (int j = 0; j < SET_N - 1 - i; j++) begin
				if (asc[j] > asc[j+1]) begin
					tmp = asc[j];
					asc[j] = asc[j+1];
					asc[j+1] = tmp;
				end
			end
		end
		for (int i = 0; i < SET_N; i++) desc[i] = asc[SET_N-1-i];
		for (int i = 0; i < SET_N; i++) push_expect(sng_pkg::KIND_ASC, int'(asc[i]), 1'b0);
		for (int i = 0; i < SET_N; i++) push_expect(sng_pkg::KIND_DESC, int'(desc[i]), 1'b0);
		for (int c = 0; c < SIDE; c++) col_sum[c] = 0;
		for (int r = 0; r < SIDE; r++) begin
			row_sum = 0;
			for (int c = 0; c < SIDE; c++) begin
				row_sum += int'(desc[r*SIDE+c]);
				col_sum[c] += int'(desc[r*SIDE+c]);
				push_expect(sng_pkg::KIND_GRID, int'(desc[r*SIDE+c]), 1'b0);
			end
			push_expect(sng_pkg::KIND_ROW, row_sum, 1'b0);
		end
		for (int c = 0; c < SIDE; c++) push_expect(sng_pkg::KIND_COL, col_sum[c], c == SIDE - 1);
	endtask

	task automatic record_sample(input logic [sng_pkg::VALUE_W-1:0] v);
		set_buf[fill] = (int'(v) > sng_pkg::CAP_INT) ? sng_pkg::VALUE_CAP : v;
		fill++;
		if (fill == SET_N) begin
			fill = 0;
			predict_report();
		end
	endtask

	task automatic send_sample(input logic [sng_pkg::VALUE_W-1:0] v);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			sample <= sng_pkg::VALUE_W'($urandom);
			repeat (gap) @(posedge clk);
		end
		sample <= v;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		record_sample(v);
		samples_sent++;
	endtask

	function automatic logic [sng_pkg::VALUE_W-1:0] pick_value(input sample_mix_t mix,
			input logic [sng_pkg::VALUE_W-1:0] base);
		logic [sng_pkg::VALUE_W-1:0] v;
		case (mix)
			MIX_FULL: v = sng_pkg::VALUE_W'($urandom_range(0, 127));
			MIX_NEAR_CAP: v = sng_pkg::VALUE_W'($urandom_range(95, 127));
			MIX_TINY: v = sng_pkg::VALUE_W'($urandom_range(0, 3));
			default: v = base;
		endcase
		return v;
	endfunction

	task automatic test_extremes();
		logic [sng_pkg::VALUE_W-1:0] vals[SET_N];
		send_idle_pct = 0;
		stall_pct = 0;
		vals = '{7'd0, 7'd100, 7'd101, 7'd127, 7'd1, 7'd64, 7'd99, 7'd0, 7'd127};
		for (int i = 0; i < SET_N; i++) send_sample(vals[i]);
	endtask

	task automatic test_saturation();
		send_idle_pct = 0;
		stall_pct = 0;
		for (int i = 0; i < SET_N; i++) send_sample(7'd127);
	endtask

	task automatic test_random_phase(input int s_pct, input int r_pct, input int sets);
		sample_mix_t mix;
		logic [sng_pkg::VALUE_W-1:0] base;
		send_idle_pct = s_pct;
		stall_pct = r_pct;
		for (int s = 0; s < sets; s++) begin
			mix = sample_mix_t'($urandom_range(3));
			base = sng_pkg::VALUE_W'($urandom);
			for (int i = 0; i < SET_N; i++) send_sample(pick_value(mix, base));
		end
	endtask

	task automatic finish_run();
		sample_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d samples, checked %0d results in %0d reports", samples_sent,
			results_seen, reports_done);
		$display("covered extremes, saturation, duplicates and four idle/stall mixes");
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		report_entry_t exp_e;
		if (arst_n) begin
			if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("TEST FAILED");
				$finish;
			end else if (result_valid && !result_stall) begin
				results_seen++;
				if (report_q.size() == 0) begin
					report_mismatch("unexpected result, amount", -1, int'(amount));
				end else begin
					exp_e = report_q.pop_front();
					if (kind !== exp_e.kind)
						report_mismatch("kind", int'(exp_e.kind), int'(kind));
					if (amount !== exp_e.amount)
						report_mismatch("amount", int'(exp_e.amount), int'(amount));
					if (final_res !== exp_e.final_res)
						report_mismatch("final_res", int'(exp_e.final_res), int'(final_res));
					if (exp_e.final_res) reports_done++;
				end
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_saturation();
		test_random_phase(0, 0, 6);
		test_random_phase(80, 0, 7);
		test_random_phase(0, 80, 7);
		test_random_phase(15, 15, 7);
		finish_run();
	end

endmodule
